/* sv/mbe_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the mandelbrot escape-time block
// no dependencies
package mbe_pkg;

  localparam int CNT_BITS      = 16;
  localparam int ORIGIN_BITS   = 32;
  localparam int STEP_BITS     = 31;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_REAL   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT  = 3'd4;

  // register reset values
  localparam logic [ORIGIN_BITS-1:0] ORIGIN_REAL_RST = 32'hE000_0000;
  localparam logic [ORIGIN_BITS-1:0] ORIGIN_IMAG_RST = 32'hE800_0000;
  localparam logic [STEP_BITS-1:0]   STEP_REAL_RST   = 31'h000C_0000;
  localparam logic [STEP_BITS-1:0]   STEP_IMAG_RST   = 31'h0010_0000;
  localparam logic [CNT_BITS-1:0]    ITER_LIMIT_RST  = 16'd256;

  // control word that travels with the point from cell to cell
  typedef struct packed {
    logic                live;
    logic                done;
    logic [CNT_BITS-1:0] n;
  } mbe_ctl_t;

endpackage

/* sv/mbe_intf.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces: pixel request, result request, config write
// depends on mbe_pkg
interface mbe_pix_if #(parameter int COORD_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_res_if import mbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] iteration_count;
  logic                reached_limit;
  modport source (output valid, output iteration_count, output reached_limit, input ready);
  modport sink   (input valid, input iteration_count, input reached_limit, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/mbe_cell.sv */
`timescale 1ns / 1ps
// one escape-time iteration cell: product stage, then update and escape test
// depends on mbe_pkg
module mbe_cell import mbe_pkg::*; #(
  parameter int FRAC_BITS = 28,
  parameter int CW        = 45
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [CNT_BITS-1:0]           limit_i,
  input  logic signed [CW-1:0]          cr_i,
  input  logic signed [CW-1:0]          ci_i,
  input  mbe_ctl_t                      ctl_i,
  input  logic signed [FRAC_BITS+1:0]   zr_i,
  input  logic signed [FRAC_BITS+1:0]   zi_i,
  output mbe_ctl_t                      ctl_o,
  output logic signed [FRAC_BITS+1:0]   zr_o,
  output logic signed [FRAC_BITS+1:0]   zi_o
);

  localparam int ZB  = FRAC_BITS + 2;
  localparam int PB  = 2 * ZB;
  localparam int SB  = FRAC_BITS + 3;
  localparam int XB  = FRAC_BITS + 4;
  localparam int WB  = ((XB > CW) ? XB : CW) + 2;
  localparam int HB  = WB - FRAC_BITS - 1;
  localparam logic [SB:0] FOUR = (SB + 1)'(1) << (FRAC_BITS + 2);

  logic signed [PB-1:0] pr_rr, pr_ii, pr_ri;
  logic signed [SB-1:0] sr_q, si_q;
  logic signed [XB-1:0] x_q;
  mbe_ctl_t             ctl_s_q;

  assign pr_rr = PB'(zr_i) * PB'(zr_i);
  assign pr_ii = PB'(zi_i) * PB'(zi_i);
  assign pr_ri = PB'(zr_i) * PB'(zi_i);

  // floor division by the scale is a plain bit select in two's complement
  always_ff @(posedge clk_i) begin
    sr_q <= $signed(pr_rr[FRAC_BITS +: SB]);
    si_q <= $signed(pr_ii[FRAC_BITS +: SB]);
    x_q  <= $signed(pr_ri[FRAC_BITS-1 +: XB]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s_q <= '0;
    end else begin
      ctl_s_q <= ctl_i;
    end
  end

  logic [SB:0]          sum_sq;
  logic                 esc_sq;
  logic signed [WB-1:0] zr_w, zi_w;
  logic                 in_r, in_i;
  mbe_ctl_t             ctl_d, ctl_q;
  logic signed [ZB-1:0] zr_q, zi_q;

  assign sum_sq = {1'b0, sr_q} + {1'b0, si_q};
  assign esc_sq = (sum_sq >= FOUR);
  assign zr_w   = WB'(sr_q) - WB'(si_q) + WB'(cr_i);
  assign zi_w   = WB'(x_q) + WB'(ci_i);

  // inside the bound when |v| < 2: high bits all sign, and not exactly -2
  assign in_r = (zr_w[WB-1:FRAC_BITS+1] == '0) ||
                ((zr_w[WB-1:FRAC_BITS+1] == {HB{1'b1}}) && (zr_w[FRAC_BITS:0] != '0));
  assign in_i = (zi_w[WB-1:FRAC_BITS+1] == '0) ||
                ((zi_w[WB-1:FRAC_BITS+1] == {HB{1'b1}}) && (zi_w[FRAC_BITS:0] != '0));

  always_comb begin
    ctl_d = ctl_s_q;
    if (ctl_s_q.live && !ctl_s_q.done) begin
      if (ctl_s_q.n == limit_i) begin
        ctl_d.done = 1'b1;
      end else if (esc_sq) begin
        ctl_d.done = 1'b1;
      end else begin
        ctl_d.n    = ctl_s_q.n + CNT_BITS'(1);
        ctl_d.done = !(in_r && in_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q <= zr_w[ZB-1:0];
    zi_q <= zi_w[ZB-1:0];
  end

  assign ctl_o = ctl_q;
  assign zr_o  = zr_q;
  assign zi_o  = zi_q;

endmodule

/* sv/mandelbrot_escape_time.sv */
`timescale 1ns / 1ps
// Mandelbrot escape-time evaluator: one pixel request in, one result request out.
// Channels: pix_i takes a pixel (pixel_col, pixel_row); res_o gives iteration_count
// and reached_limit; cfg_i writes origin_real, origin_imag, step_real, step_imag
// and iter_limit by index, always ready, and is meant to be used while idle.
// The point c = origin + pixel*step is formed by a multiply and then an add.
// z is then carried around a ring of CELLS identical cells; each cell does one
// z*z + c iteration through a product register and then an update register.
// A pixel makes P cell passes: n + 1 for a pixel that hits the limit or escapes on
// the square test, n for one that escapes on the bound test, rounded up to a
// multiple of CELLS. One pixel is in the ring at a time, so a new request is not
// taken until the previous result has moved on into the output register.
// A finished result sits in the output register; the next pixel is taken while
// it waits. If the receiver stalls past the next pixel's end, that result waits
// in a hold stage and pix_i stays not ready until the output register frees up.
// Reset returns the config registers to their reset values and empties the ring
// and the output register.
// depends on mbe_pkg, mbe_intf, mbe_cell
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int CELLS      = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mbe_pix_if.sink  pix_i,
  mbe_res_if.source res_o,
  mbe_cfg_if.sink  cfg_i
);

  localparam int PRODW = COORD_BITS + STEP_BITS;
  localparam int CW    = PRODW + 2;
  localparam int ZB    = FRAC_BITS + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_INJ  = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_HOLD = 3'd5;

  // configuration registers
  logic signed [ORIGIN_BITS-1:0] org_re_q, org_im_q;
  logic [STEP_BITS-1:0]          step_re_q, step_im_q;
  logic [CNT_BITS-1:0]           limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_re_q  <= ORIGIN_REAL_RST;
      org_im_q  <= ORIGIN_IMAG_RST;
      step_re_q <= STEP_REAL_RST;
      step_im_q <= STEP_IMAG_RST;
      limit_q   <= ITER_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ORIGIN_REAL: org_re_q  <= cfg_i.data;
        REG_ORIGIN_IMAG: org_im_q  <= cfg_i.data;
        REG_STEP_REAL:   step_re_q <= cfg_i.data[STEP_BITS-1:0];
        REG_STEP_IMAG:   step_im_q <= cfg_i.data[STEP_BITS-1:0];
        REG_ITER_LIMIT:  limit_q   <= cfg_i.data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [2:0] state_q, state_d;
  logic       in_acc, out_free, last_done;

  logic [COORD_BITS-1:0] col_q, row_q;
  logic [PRODW-1:0]      prod_re_q, prod_im_q;
  logic signed [CW-1:0]  cr_q, ci_q;
  logic [CNT_BITS-1:0]   hold_cnt_q;
  logic                  hold_lim_q;
  logic                  out_valid_q;
  logic [CNT_BITS-1:0]   out_cnt_q;
  logic                  out_lim_q;

  mbe_ctl_t                ctl_c [0:CELLS];
  logic signed [ZB-1:0]    zr_c  [0:CELLS];
  logic signed [ZB-1:0]    zi_c  [0:CELLS];
  mbe_ctl_t                ring_ctl;
  logic signed [ZB-1:0]    ring_zr, ring_zi;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign in_acc      = pix_i.valid && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || res_o.ready;
  assign last_done   = ctl_c[CELLS].live && ctl_c[CELLS].done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pix_i.valid) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_INJ;
      ST_INJ:  state_d = ST_RUN;
      ST_RUN:  if (last_done) state_d = ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // point setup: multiply, then add the origin
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= pix_i.pixel_col;
      row_q <= pix_i.pixel_row;
    end
    if (state_q == ST_MUL) begin
      prod_re_q <= PRODW'(col_q) * PRODW'(step_re_q);
      prod_im_q <= PRODW'(row_q) * PRODW'(step_im_q);
    end
    if (state_q == ST_ADD) begin
      cr_q <= CW'(org_re_q) + CW'($signed({1'b0, prod_re_q}));
      ci_q <= CW'(org_im_q) + CW'($signed({1'b0, prod_im_q}));
    end
    if ((state_q == ST_RUN) && last_done) begin
      hold_cnt_q <= ctl_c[CELLS].n;
      hold_lim_q <= (ctl_c[CELLS].n == limit_q);
    end
  end

  // ring entry: fresh point on injection, otherwise the token coming back if still running
  always_comb begin
    ring_ctl = '0;
    ring_zr  = zr_c[CELLS];
    ring_zi  = zi_c[CELLS];
    if (state_q == ST_INJ) begin
      ring_ctl.live = 1'b1;
      ring_zr       = '0;
      ring_zi       = '0;
    end else if (ctl_c[CELLS].live && !ctl_c[CELLS].done) begin
      ring_ctl = ctl_c[CELLS];
    end
  end

  assign ctl_c[0] = ring_ctl;
  assign zr_c[0]  = ring_zr;
  assign zi_c[0]  = ring_zi;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    mbe_cell #(
      .FRAC_BITS (FRAC_BITS),
      .CW        (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .limit_i (limit_q),
      .cr_i    (cr_q),
      .ci_i    (ci_q),
      .ctl_i   (ctl_c[g]),
      .zr_i    (zr_c[g]),
      .zi_i    (zi_c[g]),
      .ctl_o   (ctl_c[g+1]),
      .zr_o    (zr_c[g+1]),
      .zi_o    (zi_c[g+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_HOLD) && out_free) begin
      out_cnt_q <= hold_cnt_q;
      out_lim_q <= hold_lim_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.iteration_count = out_cnt_q;
  assign res_o.reached_limit   = out_lim_q;

endmodule

/* sv/mbe_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the escape-time block, bound to the top level
// depends on mbe_pkg and mandelbrot_escape_time
module mbe_checker import mbe_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [CNT_BITS-1:0] out_count_i,
  input logic                out_limit_i
);

  // result request holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_count_i) && $stable(out_limit_i))
    else $error("result request dropped or changed while stalled");

  // one pixel at a time: busy right after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("pixel taken while previous pixel in flight");

  // z = 0 never escapes, so an escaped point did at least one iteration
  a_escape_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_limit_i |-> out_count_i != '0)
    else $error("escape reported with zero iterations");

  // setup runs through the multiply and add states, a result cannot follow the request directly
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared right after request");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_count_i (res_o.iteration_count),
  .out_limit_i (res_o.reached_limit)
);
